### rtl/lnps_pkg.sv
// shared types and constants for the last-note priority note stack
package lnps_pkg;

   // number of held notes the stack keeps
   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   typedef logic [6:0]       note_type;
   typedef logic [CNT_W-1:0] count_type;

   // event kinds
   typedef enum logic {
      OP_NOTE_ON  = 1'b0,
      OP_NOTE_OFF = 1'b1
   } op_type;

   // one note event
   typedef struct packed {
      op_type   op;
      note_type note;
   } req_type;

   // one result word
   typedef struct packed {
      note_type   current_note;
      logic       gate;
      logic [4:0] held_count;
      logic       overflow;
   } rsp_type;

endpackage

### rtl/last_note_priority_stack.sv
// top level of the last-note priority note stack
// latency: an accepted word passes through the input register and then the result register
// throughput: one word per cycle while the result port is not stalled, one result word per input word
// the held-list update is one combinational pass between input and result registers
// reset clears the count, sounding note, gate and both valid flags; list entries are not cleared
module last_note_priority_stack (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lnps_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lnps_pkg::rsp_type rsp_word
);
   import lnps_pkg::*;

   req_type in_ff;
   logic    in_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    advance;

   // move the held word on when the result register is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_word;
      end
   end

   lnps_note_list u_note_list (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (in_ff),
      .result (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/lnps_note_list.sv
// held-note list with its match, compaction and append logic
module lnps_note_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  lnps_pkg::req_type item,
   output lnps_pkg::rsp_type result
);
   import lnps_pkg::*;

   note_type  list_ff [STACK_DEPTH];
   note_type  list_in [STACK_DEPTH];
   note_type  removed [STACK_DEPTH];
   count_type count_ff, count_in;
   note_type  sound_ff, sound_in;
   logic      gate_ff, gate_in;
   logic      ovf;

   logic [STACK_DEPTH-1:0] match;
   logic [STACK_DEPTH-1:0] shift;
   logic                   hit;
   logic                   full;
   count_type              cnt_rm;
   logic [IDX_W-1:0]       top_idx;

   // find the held copy of the note (the list never holds duplicates)
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         match[i] = (count_type'(i) < count_ff) && (list_ff[i] == item.note);
      end
      hit = |match;
   end

   // entries at or above the match move down one place
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         shift[i] = 1'b0;
         for (int j = 0; j < STACK_DEPTH; j++) begin
            if (j <= i) begin
               shift[i] = shift[i] | match[j];
            end
         end
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (shift[i] && (i < STACK_DEPTH - 1)) begin
            removed[i] = list_ff[IDX_W'(i + 1)];
         end else begin
            removed[i] = list_ff[i];
         end
      end
      cnt_rm  = count_ff - count_type'(hit);
      full    = (cnt_rm == count_type'(STACK_DEPTH));
      top_idx = IDX_W'(cnt_rm - count_type'(1));
   end

   // append on note-on, pick the newest held note on note-off
   always_comb begin
      list_in  = removed;
      count_in = cnt_rm;
      sound_in = sound_ff;
      gate_in  = gate_ff;
      ovf      = 1'b0;
      unique case (item.op)
         OP_NOTE_ON: begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
               if (full) begin
                  if (i == STACK_DEPTH - 1) begin
                     list_in[i] = item.note;
                  end else begin
                     list_in[i] = removed[IDX_W'(i + 1)];
                  end
               end else if (count_type'(i) == cnt_rm) begin
                  list_in[i] = item.note;
               end
            end
            count_in = full ? count_type'(STACK_DEPTH) : cnt_rm + count_type'(1);
            sound_in = item.note;
            gate_in  = 1'b1;
            ovf      = full;
         end
         OP_NOTE_OFF: begin
            if (cnt_rm != '0) begin
               sound_in = removed[top_idx];
               gate_in  = 1'b1;
            end else begin
               gate_in  = 1'b0;
            end
         end
         default: begin
            gate_in = gate_ff;
         end
      endcase
   end

   assign result.current_note = sound_in;
   assign result.gate         = gate_in;
   assign result.held_count   = 5'(count_in);
   assign result.overflow     = ovf;

   // list storage, no reset needed: only entries below the count are read
   always_ff @(posedge clock) begin
      if (commit) begin
         list_ff <= list_in;
      end
   end

   // count, sounding note and gate
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sound_ff <= '0;
         gate_ff  <= 1'b0;
      end else if (commit) begin
         count_ff <= count_in;
         sound_ff <= sound_in;
         gate_ff  <= gate_in;
      end
   end

   // count never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(STACK_DEPTH))
      else $error("held count above depth");

   // gate high exactly while notes are held
   a_gate_count: assert property (@(posedge clock) disable iff (reset)
      gate_ff == (count_ff != '0))
      else $error("gate disagrees with held count");

   // a note-on makes its note sound
   a_note_on: assert property (@(posedge clock) disable iff (reset)
      commit && (item.op == OP_NOTE_ON) |=> gate_ff && (sound_ff == $past(item.note)))
      else $error("note-on did not take effect");

   // overflow only from a full list
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      commit && ovf |-> (count_ff == count_type'(STACK_DEPTH)))
      else $error("overflow without a full list");

endmodule
